@@ design/red_black_tree_engine_top_defines.svh @@
// assertion helpers for the tree engine
`ifndef RED_BLACK_TREE_ENGINE_TOP_DEFINES_SVH
`define RED_BLACK_TREE_ENGINE_TOP_DEFINES_SVH

`define RBT_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("rbt check failed");

`define RBT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("rbt check failed");

`endif

@@ design/rbt_pkg.sv @@
package rbt_pkg;
  localparam int MAX_NODES_DEF = 1024;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int IDX_W = 11;
  localparam int OPC_W = 3;

  localparam logic [OPC_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPC_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OPC_W-1:0] OP_MIN    = 3'd2;
  localparam logic [OPC_W-1:0] OP_MAX    = 3'd3;
  localparam logic [OPC_W-1:0] OP_NEXT   = 3'd4;
  localparam logic [OPC_W-1:0] OP_PREV   = 3'd5;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_res_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_INS_WR,
    S_DESC_RD,
    S_DESC_CMP,
    S_LINK,
    S_FIX_TEST,
    S_FIX_P,
    S_FIX_G,
    S_FIX_U,
    S_FIX_DECIDE,
    S_ROT_RD,
    S_ROT_RD2,
    S_ROT_W1,
    S_ROT_W2,
    S_ROT_W3,
    S_ROT_W4,
    S_ROT_W5,
    S_ROT_DONE,
    S_CASE3,
    S_CASE3_P,
    S_ROOT_BLK,
    S_WALK_RD,
    S_WALK_CHK,
    S_UP_RD,
    S_UP_CHK,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_t;
endpackage

@@ design/red_black_tree_engine_top.sv @@
// red-black tree engine, one request at a time, busy high while it runs
// a new request is taken only while idle, after the last one has finished
// out_strobe is high for one cycle; the receiver cannot stall
// synchronous active-low reset empties the tree; node memory is not cleared
`include "red_black_tree_engine_top_defines.svh"
module red_black_tree_engine_top #(
  parameter int MAX_NODES = rbt_pkg::MAX_NODES_DEF,
  parameter int KEY_WIDTH = rbt_pkg::KEY_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [rbt_pkg::OPC_W-1:0] in_opcode,
  input  logic [KEY_WIDTH-1:0]      in_primary_key,
  input  logic [KEY_WIDTH-1:0]      in_secondary_key,
  input  logic [KEY_WIDTH-1:0]      in_tertiary_key,
  input  logic [rbt_pkg::IDX_W-1:0] in_start_node,
  output logic                      out_strobe,
  output logic [rbt_pkg::IDX_W-1:0] out_node_index,
  output logic                      out_store_full
);
  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int PW = AW + 1; // link width, msb set means none
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [PW-1:0] NIL = {PW{1'b1}};

  typedef struct packed {
    logic [KEY_WIDTH-1:0] k1;
    logic [KEY_WIDTH-1:0] k2;
    logic [KEY_WIDTH-1:0] k3;
    logic [PW-1:0]        lc;
    logic [PW-1:0]        rc;
    logic [PW-1:0]        par;
    logic                 red;
  } node_t;

  node_t mem [MAX_NODES];
  node_t rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  node_t         wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  rbt_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] root_r, root_nxt;
  logic [rbt_pkg::OPC_W-1:0] op_r, op_nxt;
  logic [KEY_WIDTH-1:0] k1_r, k2_r, k3_r, k1_nxt, k2_nxt, k3_nxt;
  logic [PW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt, p_r, p_nxt, g_r, g_nxt;
  logic [PW-1:0] res_r, res_nxt, rx_r, rx_nxt;
  node_t nx_r, nx_nxt, ny_r, ny_nxt;
  logic gl_r, gl_nxt, pleft_r, pleft_nxt, rdir_r, rdir_nxt, c3_r, c3_nxt;
  logic [3:0] rsel_r, rsel_nxt;
  logic strobe_r, strobe_nxt, full_r, full_nxt;
  rbt_pkg::cmp_res_t cmp;

  rbt_key_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
    .a1(k1_r), .a2(k2_r), .a3(k3_r),
    .b1(rd_q.k1), .b2(rd_q.k2), .b3(rd_q.k3), .res(cmp)
  );

  function automatic logic [rbt_pkg::IDX_W-1:0] to_out(input logic [PW-1:0] v);
    logic [rbt_pkg::IDX_W+PW-1:0] t;
    if (v[PW-1]) begin
      t = '1;
    end else begin
      t = {{rbt_pkg::IDX_W{1'b0}}, v};
    end
    return t[rbt_pkg::IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rbt_pkg::S_IDLE;
      cnt_r <= '0;
      root_r <= NIL;
      strobe_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      root_r <= root_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r <= op_nxt; k1_r <= k1_nxt; k2_r <= k2_nxt; k3_r <= k3_nxt;
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; p_r <= p_nxt; g_r <= g_nxt;
    res_r <= res_nxt; rx_r <= rx_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt;
    gl_r <= gl_nxt; pleft_r <= pleft_nxt; rdir_r <= rdir_nxt; c3_r <= c3_nxt;
    rsel_r <= rsel_nxt; full_r <= full_nxt;
  end

  // next-state logic; rotation about rx_r: rdir_r 0 left, 1 right. nx = rx node, ny = pivot node
  always_comb begin
    logic [PW-1:0] pv, inner;
    logic [rbt_pkg::IDX_W+CW-1:0] tw;
    st_nxt = st_r; cnt_nxt = cnt_r; root_nxt = root_r;
    op_nxt = op_r; k1_nxt = k1_r; k2_nxt = k2_r; k3_nxt = k3_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; p_nxt = p_r; g_nxt = g_r;
    res_nxt = res_r; rx_nxt = rx_r; nx_nxt = nx_r; ny_nxt = ny_r;
    gl_nxt = gl_r; pleft_nxt = pleft_r; rdir_nxt = rdir_r; c3_nxt = c3_r;
    rsel_nxt = rsel_r; strobe_nxt = 1'b0; full_nxt = full_r;
    we = 1'b0; wa = '0; wd = rd_q; ra = x_r[AW-1:0];
    tw = '0;
    pv = rdir_r ? nx_r.lc : nx_r.rc;
    inner = rdir_r ? ny_r.rc : ny_r.lc;
    unique case (st_r)
      rbt_pkg::S_IDLE: begin
        if (start) begin
          op_nxt = in_opcode;
          k1_nxt = in_primary_key; k2_nxt = in_secondary_key; k3_nxt = in_tertiary_key;
          full_nxt = 1'b0; res_nxt = NIL; rsel_nxt = '0;
          tw = {{(CW+1){1'b0}}, in_start_node[rbt_pkg::IDX_W-2:0]};
          if (in_start_node[rbt_pkg::IDX_W-1]) begin
            x_nxt = root_r;
          end else if (tw < {{rbt_pkg::IDX_W{1'b0}}, cnt_r}) begin
            x_nxt = tw[PW-1:0];
          end else begin
            x_nxt = NIL;
          end
          case (in_opcode) inside
            rbt_pkg::OP_INSERT: begin
              if (cnt_r >= CW'(MAX_NODES)) begin
                full_nxt = 1'b1; st_nxt = rbt_pkg::S_DONE;
              end else begin
                z_nxt = cnt_r[PW-1:0]; st_nxt = rbt_pkg::S_INS_WR;
              end
            end
            rbt_pkg::OP_SEARCH: begin
              x_nxt = root_r; st_nxt = rbt_pkg::S_SRCH_RD;
            end
            rbt_pkg::OP_MIN, rbt_pkg::OP_MAX, rbt_pkg::OP_NEXT, rbt_pkg::OP_PREV: begin
              st_nxt = rbt_pkg::S_WALK_RD;
            end
            default: st_nxt = rbt_pkg::S_DONE;
          endcase
        end
      end
      rbt_pkg::S_INS_WR: begin
        we = 1'b1; wa = z_r[AW-1:0];
        wd = '{k1: k1_r, k2: k2_r, k3: k3_r, lc: NIL, rc: NIL, par: NIL, red: 1'b1};
        cnt_nxt = cnt_r + 1'b1;
        x_nxt = root_r; y_nxt = NIL; res_nxt = z_r;
        st_nxt = rbt_pkg::S_DESC_RD;
      end
      rbt_pkg::S_DESC_RD: begin
        ra = x_r[AW-1:0];
        st_nxt = x_r[PW-1] ? rbt_pkg::S_LINK : rbt_pkg::S_DESC_CMP;
        if (!x_r[PW-1]) y_nxt = x_r;
      end
      rbt_pkg::S_DESC_CMP: begin
        gl_nxt = (cmp == rbt_pkg::CMP_LT);
        x_nxt = (cmp == rbt_pkg::CMP_LT) ? rd_q.lc : rd_q.rc;
        ra = x_nxt[AW-1:0];
        st_nxt = rbt_pkg::S_DESC_RD;
      end
      rbt_pkg::S_LINK: begin
        // y node is reread here before its child link is written
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r == 4'd0) begin
          ra = z_r[AW-1:0];
          if (y_r[PW-1]) begin
            root_nxt = z_r; rsel_nxt = 4'd1;
          end else begin
            ra = y_r[AW-1:0];
          end
        end else if (rsel_r == 4'd1) begin
          ra = y_r[AW-1:0];
          if (y_r[PW-1]) rsel_nxt = 4'd2;
        end else if (rsel_r == 4'd2) begin
          if (!y_r[PW-1]) begin
            we = 1'b1; wa = y_r[AW-1:0]; wd = rd_q;
            if (gl_r) wd.lc = z_r; else wd.rc = z_r;
          end
          ra = z_r[AW-1:0];
        end else if (rsel_r == 4'd3) begin
          ra = z_r[AW-1:0];
        end else begin
          we = 1'b1; wa = z_r[AW-1:0]; wd = rd_q; wd.par = y_r;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_FIX_TEST;
        end
      end
      rbt_pkg::S_FIX_TEST: begin
        // read z to get parent
        ra = z_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0;
          if (z_r == root_r) begin
            st_nxt = rbt_pkg::S_ROOT_BLK;
          end else begin
            p_nxt = rd_q.par; st_nxt = rbt_pkg::S_FIX_P;
          end
        end
      end
      rbt_pkg::S_FIX_P: begin
        ra = p_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0;
          if (!rd_q.red) begin
            st_nxt = rbt_pkg::S_ROOT_BLK;
          end else begin
            g_nxt = rd_q.par; st_nxt = rbt_pkg::S_FIX_G;
          end
        end
      end
      rbt_pkg::S_FIX_G: begin
        ra = g_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0;
          pleft_nxt = (p_r == rd_q.lc);
          y_nxt = (p_r == rd_q.lc) ? rd_q.rc : rd_q.lc; // uncle
          st_nxt = rbt_pkg::S_FIX_U;
        end
      end
      rbt_pkg::S_FIX_U: begin
        ra = y_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0;
          c3_nxt = 1'b0;
          if (!y_r[PW-1] && rd_q.red) begin
            // recolor: uncle black now, then parent, then grandparent
            we = 1'b1; wa = y_r[AW-1:0]; wd = rd_q; wd.red = 1'b0;
            st_nxt = rbt_pkg::S_FIX_DECIDE;
          end else begin
            st_nxt = rbt_pkg::S_CASE3;
          end
        end
      end
      rbt_pkg::S_FIX_DECIDE: begin
        // recolor parent black, then grandparent red
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r == 4'd0) begin
          ra = p_r[AW-1:0];
        end else if (rsel_r == 4'd1) begin
          we = 1'b1; wa = p_r[AW-1:0]; wd = rd_q; wd.red = 1'b0;
          ra = g_r[AW-1:0];
        end else if (rsel_r == 4'd2) begin
          ra = g_r[AW-1:0];
        end else begin
          we = 1'b1; wa = g_r[AW-1:0]; wd = rd_q; wd.red = 1'b1;
          z_nxt = g_r; rsel_nxt = '0; st_nxt = rbt_pkg::S_FIX_TEST;
        end
      end
      rbt_pkg::S_CASE3: begin
        // inner child: rotate parent first
        ra = p_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0;
          if (pleft_r ? (z_r == rd_q.rc) : (z_r == rd_q.lc)) begin
            z_nxt = p_r; rx_nxt = p_r; rdir_nxt = !pleft_r; c3_nxt = 1'b1;
            st_nxt = rbt_pkg::S_ROT_RD;
          end else begin
            st_nxt = rbt_pkg::S_CASE3_P;
          end
        end
      end
      rbt_pkg::S_CASE3_P: begin
        // p = parent(z), g = parent(p); color p black, g red, rotate g
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r == 4'd0) begin
          ra = z_r[AW-1:0];
        end else if (rsel_r == 4'd1) begin
          p_nxt = rd_q.par; ra = rd_q.par[AW-1:0];
        end else if (rsel_r == 4'd2) begin
          ra = p_r[AW-1:0];
        end else if (rsel_r == 4'd3) begin
          we = 1'b1; wa = p_r[AW-1:0]; wd = rd_q; wd.red = 1'b0;
          g_nxt = rd_q.par; ra = rd_q.par[AW-1:0];
        end else if (rsel_r == 4'd4) begin
          ra = g_r[AW-1:0];
        end else begin
          we = 1'b1; wa = g_r[AW-1:0]; wd = rd_q; wd.red = 1'b1;
          rx_nxt = g_r; rdir_nxt = pleft_r; c3_nxt = 1'b0;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_RD;
        end
      end
      rbt_pkg::S_ROT_RD: begin
        ra = rx_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0; nx_nxt = rd_q;
          ra = rdir_r ? rd_q.lc[AW-1:0] : rd_q.rc[AW-1:0];
          st_nxt = rbt_pkg::S_ROT_RD2;
        end
      end
      rbt_pkg::S_ROT_RD2: begin
        ra = pv[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          rsel_nxt = '0; ny_nxt = rd_q;
          st_nxt = rbt_pkg::S_ROT_W1;
        end
      end
      rbt_pkg::S_ROT_W1: begin
        // inner subtree gets new parent rx
        rsel_nxt = rsel_r + 1'b1;
        ra = inner[AW-1:0];
        if (inner[PW-1]) begin
          rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_W2;
        end else if (rsel_r != 4'd0) begin
          we = 1'b1; wa = inner[AW-1:0]; wd = rd_q; wd.par = rx_r;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_W2;
        end
      end
      rbt_pkg::S_ROT_W2: begin
        // fix the link from rx's old parent
        rsel_nxt = rsel_r + 1'b1;
        ra = nx_r.par[AW-1:0];
        if (nx_r.par[PW-1]) begin
          root_nxt = pv; rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_W3;
        end else if (rsel_r != 4'd0) begin
          we = 1'b1; wa = nx_r.par[AW-1:0]; wd = rd_q;
          if (rd_q.lc == rx_r) wd.lc = pv; else wd.rc = pv;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_W3;
        end
      end
      rbt_pkg::S_ROT_W3: begin
        // rx: inner child in place of pivot, parent pivot; colors reread
        rsel_nxt = rsel_r + 1'b1;
        ra = rx_r[AW-1:0];
        if (rsel_r != 4'd0) begin
          we = 1'b1; wa = rx_r[AW-1:0]; wd = rd_q; wd.par = pv;
          if (rdir_r) wd.lc = inner; else wd.rc = inner;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_W4;
        end
      end
      rbt_pkg::S_ROT_W4: begin
        rsel_nxt = rsel_r + 1'b1;
        ra = pv[AW-1:0];
        if (rsel_r != 4'd0) begin
          we = 1'b1; wa = pv[AW-1:0]; wd = rd_q; wd.par = nx_r.par;
          if (rdir_r) wd.rc = rx_r; else wd.lc = rx_r;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_ROT_DONE;
        end
      end
      rbt_pkg::S_ROT_W5: begin
        st_nxt = rbt_pkg::S_ROT_DONE;
      end
      rbt_pkg::S_ROT_DONE: begin
        // after the inner rotation go on with the outer case, else loop test
        st_nxt = c3_r ? rbt_pkg::S_CASE3_P : rbt_pkg::S_FIX_TEST;
        c3_nxt = 1'b0;
      end
      rbt_pkg::S_ROOT_BLK: begin
        ra = root_r[AW-1:0];
        rsel_nxt = rsel_r + 1'b1;
        if (rsel_r != 4'd0) begin
          we = 1'b1; wa = root_r[AW-1:0]; wd = rd_q; wd.red = 1'b0;
          rsel_nxt = '0; st_nxt = rbt_pkg::S_DONE;
        end
      end
      rbt_pkg::S_WALK_RD: begin
        ra = x_r[AW-1:0];
        if (x_r[PW-1]) begin
          st_nxt = rbt_pkg::S_DONE;
        end else begin
          st_nxt = rbt_pkg::S_WALK_CHK;
        end
      end
      rbt_pkg::S_WALK_CHK: begin
        // min/max: follow one side; next/prev: one step then min/max or climb
        if (op_r == rbt_pkg::OP_MIN || op_r == rbt_pkg::OP_MAX) begin
          y_nxt = (op_r == rbt_pkg::OP_MIN) ? rd_q.lc : rd_q.rc;
          if (y_nxt[PW-1]) begin
            res_nxt = x_r; st_nxt = rbt_pkg::S_DONE;
          end else begin
            x_nxt = y_nxt; ra = y_nxt[AW-1:0]; st_nxt = rbt_pkg::S_WALK_RD;
          end
        end else begin
          y_nxt = (op_r == rbt_pkg::OP_NEXT) ? rd_q.rc : rd_q.lc;
          if (!y_nxt[PW-1]) begin
            op_nxt = (op_r == rbt_pkg::OP_NEXT) ? rbt_pkg::OP_MIN : rbt_pkg::OP_MAX;
            x_nxt = y_nxt; st_nxt = rbt_pkg::S_WALK_RD;
          end else begin
            y_nxt = rd_q.par; st_nxt = rbt_pkg::S_UP_RD;
          end
        end
      end
      rbt_pkg::S_UP_RD: begin
        ra = y_r[AW-1:0];
        if (y_r[PW-1]) begin
          res_nxt = NIL; st_nxt = rbt_pkg::S_DONE;
        end else begin
          st_nxt = rbt_pkg::S_UP_CHK;
        end
      end
      rbt_pkg::S_UP_CHK: begin
        if (x_r == ((op_r == rbt_pkg::OP_NEXT) ? rd_q.rc : rd_q.lc)) begin
          x_nxt = y_r; y_nxt = rd_q.par; st_nxt = rbt_pkg::S_UP_RD;
        end else begin
          res_nxt = y_r; st_nxt = rbt_pkg::S_DONE;
        end
      end
      rbt_pkg::S_SRCH_RD: begin
        ra = x_r[AW-1:0];
        if (x_r[PW-1]) begin
          res_nxt = NIL; st_nxt = rbt_pkg::S_DONE;
        end else begin
          st_nxt = rbt_pkg::S_SRCH_CMP;
        end
      end
      rbt_pkg::S_SRCH_CMP: begin
        if (cmp == rbt_pkg::CMP_EQ) begin
          res_nxt = x_r; st_nxt = rbt_pkg::S_DONE;
        end else begin
          x_nxt = (cmp == rbt_pkg::CMP_LT) ? rd_q.lc : rd_q.rc;
          st_nxt = rbt_pkg::S_SRCH_RD;
        end
      end
      rbt_pkg::S_DONE: begin
        strobe_nxt = 1'b1; st_nxt = rbt_pkg::S_IDLE;
      end
      default: st_nxt = rbt_pkg::S_IDLE;
    endcase
  end

  assign busy = (st_r != rbt_pkg::S_IDLE);
  assign out_strobe = strobe_r;
  assign out_node_index = to_out(res_r);
  assign out_store_full = full_r;

  `RBT_ASSERT_NEXT(a_done_strobe, clk, rst_n, st_r == rbt_pkg::S_DONE, out_strobe)
  `RBT_ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_strobe, !busy)
  `RBT_ASSERT_IMPL(a_full_none, clk, rst_n, out_strobe && out_store_full,
                   out_node_index[rbt_pkg::IDX_W-1])
endmodule

@@ design/rbt_key_cmp.sv @@
module rbt_key_cmp #(
  parameter int KEY_WIDTH = rbt_pkg::KEY_WIDTH_DEF
) (
  input  logic [KEY_WIDTH-1:0] a1,
  input  logic [KEY_WIDTH-1:0] a2,
  input  logic [KEY_WIDTH-1:0] a3,
  input  logic [KEY_WIDTH-1:0] b1,
  input  logic [KEY_WIDTH-1:0] b2,
  input  logic [KEY_WIDTH-1:0] b3,
  output rbt_pkg::cmp_res_t    res
);
  // signed lexicographic compare of three key parts
  always_comb begin
    if (a1 != b1) begin
      res = ($signed(a1) < $signed(b1)) ? rbt_pkg::CMP_LT : rbt_pkg::CMP_GT;
    end else if (a2 != b2) begin
      res = ($signed(a2) < $signed(b2)) ? rbt_pkg::CMP_LT : rbt_pkg::CMP_GT;
    end else if (a3 != b3) begin
      res = ($signed(a3) < $signed(b3)) ? rbt_pkg::CMP_LT : rbt_pkg::CMP_GT;
    end else begin
      res = rbt_pkg::CMP_EQ;
    end
  end
endmodule
